[rtl/ntqs_pkg.sv]
`default_nettype none
package ntqs_pkg;

	// field widths
	localparam int TICK_W  = 26;
	localparam int BAR_W   = 16;
	localparam int IDX_W   = 10;
	localparam int STEP_W  = 10;
	localparam int SW_W    = 7;
	localparam int NOTE_W  = 7;

	// bar table
	localparam int MAX_BARS = 1024;
	localparam int AW       = $clog2(MAX_BARS);
	localparam int ACC_W    = BAR_W + AW;

	// divider widths
	localparam int DVD_W = TICK_W;
	localparam int DSR_W = STEP_W + 1;

	// arithmetic constants
	localparam logic [TICK_W-1:0] TICK_MAX    = {TICK_W{1'b1}};
	localparam logic [TICK_W:0]   STEP_CAP    = (TICK_W+1)'(999);
	localparam logic [STEP_W-1:0] STEP_A      = STEP_W'(24);
	localparam logic [STEP_W-1:0] STEP_B      = STEP_W'(48);
	localparam logic [SW_W-1:0]   SWING_NONE  = SW_W'(50);
	localparam int                SWING_RECIP = 1311;
	localparam int                RECIP_SH    = 15;

	// configuration port
	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_WSTART = 3'd0;
	localparam logic [2:0] REG_WEND   = 3'd1;
	localparam logic [2:0] REG_STEP   = 3'd2;
	localparam logic [2:0] REG_SWING  = 3'd3;
	localparam logic [2:0] REG_LOW    = 3'd4;
	localparam logic [2:0] REG_HIGH   = 3'd5;

	// input kinds
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_CORRECT = 1'b1;

	typedef struct packed {
		logic [TICK_W-1:0] window_start;
		logic [TICK_W-1:0] window_end;
		logic [STEP_W-1:0] step_length;
		logic [SW_W-1:0]   swing_percent;
		logic [NOTE_W-1:0] lowest_note;
		logic [NOTE_W-1:0] highest_note;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quo;
		logic [DSR_W-1:0] rem;
	} div_rsp_t;

endpackage
`default_nettype wire

[rtl/note_timing_quantizer_swing_top.sv]
`default_nettype none
// channel   dir  handshake          word
// s_*       in   s_tvalid/s_tready  tdata: bar_index, bar_ticks, note_tick, note_number
//                                   tuser: opcode
// m_*       out  m_tvalid/m_tready  tdata: corrected_tick; tuser: was_corrected
// apb       in   psel/penable       six registers at byte address 4*i
//
// After reset the bar table is cleared, one entry a cycle, while s_tready is low.
// A load word is written to the table as it is accepted. A correct word outside the
// window or range goes straight to the output; one inside takes a full walk of the bar
// table through its single read port, then up to two serial divisions (rounding and swing
// parity). A finished word waits in the output register while the next word is taken.
module note_timing_quantizer_swing_top import ntqs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// bar_index[9:0], bar_ticks[25:10], note_tick[51:26], note_number[58:52]
	input  wire logic [63:0]        s_tdata,
	// opcode[0]
	input  wire logic [0:0]         s_tuser,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// corrected_tick[25:0]
	output logic      [31:0]        m_tdata,
	// was_corrected[0]
	output logic      [0:0]         m_tuser,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_SCAN  = 10'b0000000100,
		ST_FIN   = 10'b0000001000,
		ST_DIV1  = 10'b0000010000,
		ST_MUL   = 10'b0000100000,
		ST_APPLY = 10'b0001000000,
		ST_DIV2  = 10'b0010000000,
		ST_SWING = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t            state_q;
	cfg_t              cfg;
	div_req_t          dreq;
	div_rsp_t          drsp;

	logic [AW:0]       clr_q;
	logic [AW-1:0]     addr_q;
	logic              iss_q;
	logic              rv_s1;
	logic [AW-1:0]     ridx_s1;
	logic [BAR_W-1:0]  rdata;

	logic [TICK_W-1:0] tick_q;
	logic [ACC_W-1:0]  acc_q;
	logic [BAR_W-1:0]  bar0_q;
	logic              from_f_q, to_f_q, bar_f_q;
	logic [AW-1:0]     from_idx_q, to_idx_q;
	logic [ACC_W-1:0]  from_prev_q, to_sum_q, bs_q;
	logic [BAR_W-1:0]  len_q;
	logic [ACC_W-1:0]  bs_e_q, seg_end_q, seg_start_q;
	logic [BAR_W-1:0]  len_e_q;
	logic              cand_q;
	logic [TICK_W:0]   i_q;
	logic [TICK_W+STEP_W:0] prod_q;
	logic [ACC_W:0]    t_q;
	logic              corr_q;
	logic              out_v_q;
	logic [TICK_W-1:0] out_tick_q;
	logic              out_corr_q;

	logic              acc_in;
	logic [BAR_W-1:0]  in_ticks;
	logic [IDX_W-1:0]  in_idx;
	logic [TICK_W-1:0] in_tick;
	logic [NOTE_W-1:0] in_note;
	logic              in_range;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BAR_W-1:0]  ram_wdata;
	logic [ACC_W-1:0]  acc_new;
	logic [ACC_W-1:0]  bs_e, seg_end_e, seg_start_e;
	logic [AW-1:0]     to_idx_e;
	logic [TICK_W-1:0] off;
	logic [STEP_W-1:0] half;
	logic              step_zero;
	logic              need_swing;
	logic              prod_ok;
	logic [ACC_W+1:0]  t_sum;
	logic [SW_W-1:0]   sw_x;
	logic [11:0]       sw_y;
	logic [23:0]       sw_p;
	logic [7:0]        sw_add;
	logic              odd_step;

	ntqs_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	ntqs_div u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));

	ntqs_ram #(.WIDTH(BAR_W), .DEPTH(MAX_BARS)) u_ram (
		.clk,
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(rdata)
	);

	// input word fields
	assign in_idx   = s_tdata[9:0];
	assign in_ticks = s_tdata[25:10];
	assign in_tick  = s_tdata[51:26];
	assign in_note  = s_tdata[58:52];
	assign s_tready = (state_q == ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign in_range = (in_tick >= cfg.window_start) && (in_tick < cfg.window_end) &&
	                  (in_note >= cfg.lowest_note) && (in_note <= cfg.highest_note);

	// table write: clearing sweep or a load word
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q[AW-1:0];
			ram_wdata = '0;
		end else begin
			ram_we    = acc_in && (s_tuser[0] == OP_LOAD) &&
			            ((IDX_W+1)'(in_idx) < (IDX_W+1)'(MAX_BARS));
			ram_waddr = AW'(in_idx);
			ram_wdata = in_ticks;
		end
	end

	// walk arithmetic
	assign acc_new = acc_q + ACC_W'(rdata);

	// segment and bar selection after the walk
	assign bs_e        = bar_f_q ? bs_q : '0;
	assign seg_end_e   = to_f_q ? to_sum_q : ACC_W'(bar0_q);
	assign to_idx_e    = to_f_q ? to_idx_q : '0;
	assign seg_start_e = !from_f_q ? '0 :
	                     (from_idx_q <= to_idx_e) ? from_prev_q : seg_end_e;
	assign off         = tick_q - TICK_W'(bs_e);
	assign half        = cfg.step_length >> 1;
	assign step_zero   = (cfg.step_length == '0);
	assign need_swing  = ((cfg.step_length == STEP_A) || (cfg.step_length == STEP_B)) &&
	                     (cfg.swing_percent > SWING_NONE);

	// step check and rounded tick
	assign prod_ok = (prod_q <= (TICK_W+STEP_W+1)'(len_e_q)) && (i_q <= STEP_CAP);
	assign t_sum   = (ACC_W+2)'(bs_e_q) + (ACC_W+2)'(prod_q);

	// swing amount: floor(x*step/50) as a reciprocal multiply
	assign sw_x     = cfg.swing_percent - SWING_NONE;
	assign sw_y     = (cfg.step_length == STEP_A) ? 12'(sw_x) * 12'd12 : 12'(sw_x) * 12'd24;
	assign sw_p     = 24'(sw_y) * 24'(SWING_RECIP);
	assign sw_add   = 8'(sw_p >> RECIP_SH);
	assign odd_step = (drsp.rem == DSR_W'(cfg.step_length));

	// divider requests
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = off - TICK_W'(half);
		dreq.divisor  = DSR_W'(cfg.step_length);
		if (state_q == ST_FIN) begin
			dreq.start = !step_zero && (off > TICK_W'(half));
		end else if (state_q == ST_APPLY) begin
			dreq.start    = need_swing;
			dreq.dividend = t_sum[TICK_W-1:0];
			if (!prod_ok || !cand_q) begin
				dreq.dividend = tick_q;
			end else if (t_sum >= (ACC_W+2)'(seg_end_q)) begin
				dreq.dividend = seg_start_q[TICK_W-1:0];
			end
			dreq.divisor = DSR_W'({cfg.step_length, 1'b0});
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((state_q == ST_OUT) && (!out_v_q || m_tready)) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			iss_q   <= 1'b0;
			rv_s1   <= 1'b0;
		end else begin
			rv_s1 <= (state_q == ST_SCAN) && iss_q;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MAX_BARS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc_in && (s_tuser[0] == OP_CORRECT)) begin
						if (in_range) begin
							state_q <= ST_SCAN;
							iss_q   <= 1'b1;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SCAN: begin
					if (iss_q && (addr_q == AW'(MAX_BARS - 1))) begin
						iss_q <= 1'b0;
					end
					if (rv_s1 && (ridx_s1 == AW'(MAX_BARS - 1))) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= dreq.start ? ST_DIV1 : ST_MUL;
				end
				ST_DIV1: begin
					if (drsp.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					state_q <= need_swing ? ST_DIV2 : ST_OUT;
				end
				ST_DIV2: begin
					if (drsp.done) begin
						state_q <= ST_SWING;
					end
				end
				ST_SWING: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_v_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk and arithmetic datapath
	always_ff @(posedge clk) begin
		ridx_s1 <= addr_q;
		case (state_q)
			ST_IDLE: begin
				tick_q   <= in_tick;
				t_q      <= (ACC_W+1)'(in_tick);
				addr_q   <= '0;
				acc_q    <= '0;
				from_f_q <= 1'b0;
				to_f_q   <= 1'b0;
				bar_f_q  <= 1'b0;
				if (acc_in) begin
					corr_q <= in_range;
				end
			end
			ST_SCAN: begin
				if (iss_q) begin
					addr_q <= addr_q + 1'b1;
				end
				if (rv_s1) begin
					acc_q <= acc_new;
					if (ridx_s1 == '0) begin
						bar0_q <= rdata;
					end
					if (!from_f_q && (acc_new >= ACC_W'(cfg.window_start))) begin
						from_f_q    <= 1'b1;
						from_idx_q  <= ridx_s1;
						from_prev_q <= acc_q;
					end
					if (!to_f_q && (acc_new > ACC_W'(cfg.window_end))) begin
						to_f_q   <= 1'b1;
						to_idx_q <= ridx_s1;
						to_sum_q <= acc_new;
					end
					if (!bar_f_q && (ACC_W'(tick_q) < acc_new)) begin
						bar_f_q <= 1'b1;
						bs_q    <= acc_q;
						len_q   <= rdata;
					end
				end
			end
			ST_FIN: begin
				bs_e_q      <= bs_e;
				len_e_q     <= bar_f_q ? len_q : bar0_q;
				seg_end_q   <= seg_end_e;
				seg_start_q <= seg_start_e;
				i_q         <= '0;
				cand_q      <= step_zero ? (off == '0) : 1'b1;
			end
			ST_DIV1: begin
				if (drsp.done) begin
					i_q <= (TICK_W+1)'(drsp.quo) + (TICK_W+1)'(drsp.rem != '0);
				end
			end
			ST_MUL: begin
				prod_q <= i_q * (TICK_W+STEP_W+1)'(cfg.step_length);
			end
			ST_APPLY: begin
				t_q <= (ACC_W+1)'(dreq.dividend);
				if (cand_q && prod_ok) begin
					t_q <= (t_sum >= (ACC_W+2)'(seg_end_q)) ? (ACC_W+1)'(seg_start_q) :
					       (ACC_W+1)'(t_sum);
				end
			end
			ST_SWING: begin
				if (odd_step) begin
					t_q <= t_q + (ACC_W+1)'(sw_add);
				end
			end
			ST_OUT: begin
				if (!out_v_q || m_tready) begin
					out_tick_q <= (t_q > (ACC_W+1)'(TICK_MAX)) ? TICK_MAX : t_q[TICK_W-1:0];
					out_corr_q <= corr_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = 32'(out_tick_q);
	assign m_tuser[0] = out_corr_q;

endmodule
`default_nettype wire

[rtl/ntqs_ram.sv]
`default_nettype none
module ntqs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/ntqs_div.sv]
`default_nettype none
module ntqs_div import ntqs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   rem_sh;
	logic             fits;

	// restoring step: one quotient bit a cycle
	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DSR_W'(rem_sh - {1'b0, dsr_q});
			end else begin
				rem_q <= rem_sh[DSR_W-1:0];
			end
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

[rtl/ntqs_cfg.sv]
`default_nettype none
module ntqs_cfg import ntqs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_start  <= '0;
			cfg_q.window_end    <= '0;
			cfg_q.step_length   <= STEP_A;
			cfg_q.swing_percent <= SWING_NONE;
			cfg_q.lowest_note   <= '0;
			cfg_q.highest_note  <= {NOTE_W{1'b1}};
		end else if (wr) begin
			case (idx)
				REG_WSTART: cfg_q.window_start  <= pwdata[TICK_W-1:0];
				REG_WEND:   cfg_q.window_end    <= pwdata[TICK_W-1:0];
				REG_STEP:   cfg_q.step_length   <= pwdata[STEP_W-1:0];
				REG_SWING:  cfg_q.swing_percent <= pwdata[SW_W-1:0];
				REG_LOW:    cfg_q.lowest_note   <= pwdata[NOTE_W-1:0];
				REG_HIGH:   cfg_q.highest_note  <= pwdata[NOTE_W-1:0];
				default: ;
			endcase
		end
	end

	// read-back
	always_comb begin
		case (idx)
			REG_WSTART: prdata = 32'(cfg_q.window_start);
			REG_WEND:   prdata = 32'(cfg_q.window_end);
			REG_STEP:   prdata = 32'(cfg_q.step_length);
			REG_SWING:  prdata = 32'(cfg_q.swing_percent);
			REG_LOW:    prdata = 32'(cfg_q.lowest_note);
			REG_HIGH:   prdata = 32'(cfg_q.highest_note);
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire
